[rtl/ibcl_pkg.sv]
// shared types, constants and helpers for the imu bias calibrate low-pass block
`timescale 1ns / 1ps
package ibcl_pkg;

	localparam int NAXES = 6;
	localparam int NACCEL = 3;
	localparam int AXIS_AX = 0;
	localparam int AXIS_AY = 1;
	localparam int AXIS_AZ = 2;
	localparam int AXIS_GX = 3;
	localparam int AXIS_GY = 4;
	localparam int AXIS_GZ = 5;

	localparam int RAW_W = 16;
	localparam int DATA_W = 24;
	localparam int ALPHA_W = 16;
	localparam int ONEG_W = 15;
	localparam int SUM_W = 32;
	localparam int FRAC_BITS = 8;

	// calibration length, a power of two
	localparam int CAL_SAMPLES = 16384;
	localparam int CAL_SHIFT = $clog2(CAL_SAMPLES);
	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

	// filter datapath widths
	localparam int X_W = DATA_W + 2;
	localparam int PROD_W = X_W + ALPHA_W + 1;
	localparam int RND_W = PROD_W - ALPHA_W;
	localparam int NEWF_W = RND_W + 1;

	// bias datapath widths
	localparam int NUM_W = SUM_W + FRAC_BITS + 1;
	localparam int SAT_IN_W = NUM_W + 2;

	// register map
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_ACCEL_ALPHA = 2'd1;
	localparam logic [1:0] REG_GYRO_ALPHA = 2'd2;
	localparam logic [1:0] REG_ACCEL_ONE_G = 2'd3;

	localparam logic [ALPHA_W-1:0] ACCEL_ALPHA_RST = ALPHA_W'(9175);
	localparam logic [ALPHA_W-1:0] GYRO_ALPHA_RST = ALPHA_W'(6554);
	localparam logic [ONEG_W-1:0] ONE_G_RST = ONEG_W'(16384);

	typedef logic [NAXES-1:0][DATA_W-1:0] lane_vec_t;

	typedef struct packed {
		logic step;
		logic cal;
		logic cal_last;
	} lane_ctrl_t;

	typedef struct packed {
		lane_vec_t axis;
		logic calibrating;
		logic done;
	} res_t;

	localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(2 ** (DATA_W - 1) - 1);
	localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_IN_W'(2 ** (DATA_W - 1));

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_IN_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[DATA_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/ibcl_lane.sv]
// one axis lane: bias calibration sum, stored bias and low-pass filter
`timescale 1ns / 1ps
module ibcl_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ibcl_pkg::lane_ctrl_t                ctrl,
	input  logic signed [ibcl_pkg::RAW_W-1:0]   raw,
	input  logic [ibcl_pkg::ALPHA_W-1:0]        alpha,
	input  logic [ibcl_pkg::ONEG_W-1:0]         bias_offset,
	output logic [ibcl_pkg::DATA_W-1:0]         filt_next
);
	import ibcl_pkg::*;

	logic signed [DATA_W-1:0] filt_q;
	logic signed [DATA_W-1:0] bias_q;
	logic signed [SUM_W-1:0] sum_q;

	logic signed [X_W-1:0] x;
	logic signed [X_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [RND_W-1:0] rnd;
	logic signed [NEWF_W-1:0] filt_sum;
	logic signed [DATA_W-1:0] filt_upd;

	logic signed [SUM_W-1:0] new_sum;
	logic sum_neg;
	logic [SUM_W-1:0] mag;
	logic [NUM_W-1:0] num_mag;
	logic [NUM_W-1:0] q;
	logic signed [NUM_W:0] q_s;
	logic signed [SAT_IN_W-1:0] off_s;
	logic signed [SAT_IN_W-1:0] bias_raw;
	logic signed [DATA_W-1:0] bias_new;

	localparam logic signed [PROD_W-1:0] ALPHA_HALF = PROD_W'(2 ** (ALPHA_W - 1));

	// filter: prev + round(alpha * (x - prev) / 2^16)
	always_comb begin
		x = (X_W'(raw) <<< FRAC_BITS) - X_W'(bias_q);
		diff = x - X_W'(filt_q);
		prod = $signed({1'b0, alpha}) * diff;
		prod_rnd = prod + ALPHA_HALF;
		rnd = $signed(prod_rnd[PROD_W-1:ALPHA_W]);
		filt_sum = NEWF_W'(filt_q) + NEWF_W'(rnd);
		filt_upd = sat_data(SAT_IN_W'(filt_sum));
	end

	// bias: rounded average, ties away from zero, minus offset
	always_comb begin
		new_sum = sum_q + SUM_W'(raw);
		sum_neg = new_sum[SUM_W-1];
		mag = sum_neg ? SUM_W'(-new_sum) : SUM_W'(new_sum);
		num_mag = NUM_W'(mag) << FRAC_BITS;
		q = (num_mag + NUM_W'(CAL_SAMPLES / 2)) >> CAL_SHIFT;
		q_s = sum_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		off_s = SAT_IN_W'($signed({1'b0, bias_offset})) <<< FRAC_BITS;
		bias_raw = SAT_IN_W'(q_s) - off_s;
		bias_new = sat_data(bias_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
			bias_q <= '0;
			sum_q <= '0;
		end else if (ctrl.step) begin
			if (ctrl.cal) begin
				if (ctrl.cal_last) begin
					bias_q <= bias_new;
					sum_q <= '0;
				end else begin
					sum_q <= new_sum;
				end
			end else begin
				filt_q <= filt_upd;
				sum_q <= '0;
			end
		end
	end

	assign filt_next = (ctrl.cal) ? filt_q : filt_upd;

endmodule

[rtl/ibcl_merge.sv]
// merges lane results and flags into the output register with a skid stage
`timescale 1ns / 1ps
module ibcl_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ibcl_pkg::lane_ctrl_t  ctrl,
	input  ibcl_pkg::lane_vec_t   lane_filt,
	input  logic                  result_stall,
	output logic                  result_valid,
	output ibcl_pkg::res_t        res_q,
	output logic                  sample_stall
);
	import ibcl_pkg::*;

	res_t res_new;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic pop;

	always_comb begin
		res_new.axis = lane_filt;
		res_new.calibrating = ctrl.cal & ~ctrl.cal_last;
		res_new.done = ctrl.cal & ctrl.cal_last;
	end

	assign pop = out_valid_q & ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (ctrl.step) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				res_q <= skid_q;
			end
		end else if (ctrl.step) begin
			if (!out_valid_q || pop) begin
				res_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign sample_stall = skid_valid_q;

endmodule

[rtl/imu_bias_calibrate_lowpass_core.sv]
// IMU bias calibration and per-axis low-pass filter, one item per cycle unless stalled
// Usage:
//   The sample channel (sample_valid / sample_stall) takes one six-axis raw item:
//   three accelerometer and three gyro axes, 16-bit two's complement.
//   The result channel (result_valid / result_stall) returns one item per sample:
//   six filtered axes in counts with 8 fraction bits, plus calibrating and
//   calibration_done flags.
//   Six axis lanes work side by side; each does one multiply-add per item, so
//   a new item is taken every cycle while sample_stall is low, its result registered.
//   A result waiting on result_stall goes to a one-item skid stage, so one more
//   sample is taken; sample_stall rises only when that skid stage is full.
//   mode = 1 sums 16384 items per axis and then stores the rounded average as
//   the bias (one g removed from accel Z); mode = 0 subtracts bias and filters.
//   Write registers over APB only while idle. Reset clears filter state,
//   biases, sums and count, and loads the default coefficients.
`timescale 1ns / 1ps
module imu_bias_calibrate_lowpass_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ibcl_pkg::PADDR_W-1:0]        paddr,
	input  logic [ibcl_pkg::PDATA_W-1:0]        pwdata,
	output logic [ibcl_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [ibcl_pkg::RAW_W-1:0]   accel_x,
	input  logic signed [ibcl_pkg::RAW_W-1:0]   accel_y,
	input  logic signed [ibcl_pkg::RAW_W-1:0]   accel_z,
	input  logic signed [ibcl_pkg::RAW_W-1:0]   gyro_x,
	input  logic signed [ibcl_pkg::RAW_W-1:0]   gyro_y,
	input  logic signed [ibcl_pkg::RAW_W-1:0]   gyro_z,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [ibcl_pkg::DATA_W-1:0]  out_accel_x,
	output logic signed [ibcl_pkg::DATA_W-1:0]  out_accel_y,
	output logic signed [ibcl_pkg::DATA_W-1:0]  out_accel_z,
	output logic signed [ibcl_pkg::DATA_W-1:0]  out_gyro_x,
	output logic signed [ibcl_pkg::DATA_W-1:0]  out_gyro_y,
	output logic signed [ibcl_pkg::DATA_W-1:0]  out_gyro_z,
	output logic                                calibrating,
	output logic                                calibration_done
);
	import ibcl_pkg::*;

	logic mode_q;
	logic [ALPHA_W-1:0] accel_alpha_q;
	logic [ALPHA_W-1:0] gyro_alpha_q;
	logic [ONEG_W-1:0] one_g_q;
	logic [CNT_W-1:0] cal_count_q;

	logic cfg_wr;
	logic [1:0] reg_idx;
	logic sample_accept;
	lane_ctrl_t ctrl;
	logic signed [RAW_W-1:0] raw_vec [NAXES];
	logic [ALPHA_W-1:0] lane_alpha [NAXES];
	logic [ONEG_W-1:0] lane_off [NAXES];
	lane_vec_t lane_filt;
	res_t res_q;

	// register port
	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			accel_alpha_q <= ACCEL_ALPHA_RST;
			gyro_alpha_q <= GYRO_ALPHA_RST;
			one_g_q <= ONE_G_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MODE: mode_q <= pwdata[0];
				REG_ACCEL_ALPHA: accel_alpha_q <= pwdata[ALPHA_W-1:0];
				REG_GYRO_ALPHA: gyro_alpha_q <= pwdata[ALPHA_W-1:0];
				REG_ACCEL_ONE_G: one_g_q <= pwdata[ONEG_W-1:0];
				default: mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE: prdata = PDATA_W'(mode_q);
			REG_ACCEL_ALPHA: prdata = PDATA_W'(accel_alpha_q);
			REG_GYRO_ALPHA: prdata = PDATA_W'(gyro_alpha_q);
			REG_ACCEL_ONE_G: prdata = PDATA_W'(one_g_q);
			default: prdata = '0;
		endcase
	end

	// calibration sample count
	assign sample_accept = sample_valid & ~sample_stall;
	assign ctrl.step = sample_accept;
	assign ctrl.cal = mode_q;
	assign ctrl.cal_last = (cal_count_q == CNT_W'(CAL_SAMPLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_count_q <= '0;
		end else if (sample_accept) begin
			if (mode_q && !ctrl.cal_last) begin
				cal_count_q <= cal_count_q + 1'b1;
			end else begin
				cal_count_q <= '0;
			end
		end
	end

	// axis lanes
	assign raw_vec[AXIS_AX] = accel_x;
	assign raw_vec[AXIS_AY] = accel_y;
	assign raw_vec[AXIS_AZ] = accel_z;
	assign raw_vec[AXIS_GX] = gyro_x;
	assign raw_vec[AXIS_GY] = gyro_y;
	assign raw_vec[AXIS_GZ] = gyro_z;

	for (genvar g = 0; g < NAXES; g++) begin : g_lane
		assign lane_alpha[g] = (g < NACCEL) ? accel_alpha_q : gyro_alpha_q;
		assign lane_off[g] = (g == AXIS_AZ) ? one_g_q : '0;

		ibcl_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.raw         (raw_vec[g]),
			.alpha       (lane_alpha[g]),
			.bias_offset (lane_off[g]),
			.filt_next   (lane_filt[g])
		);
	end

	ibcl_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.lane_filt    (lane_filt),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.res_q        (res_q),
		.sample_stall (sample_stall)
	);

	assign out_accel_x = res_q.axis[AXIS_AX];
	assign out_accel_y = res_q.axis[AXIS_AY];
	assign out_accel_z = res_q.axis[AXIS_AZ];
	assign out_gyro_x = res_q.axis[AXIS_GX];
	assign out_gyro_y = res_q.axis[AXIS_GY];
	assign out_gyro_z = res_q.axis[AXIS_GZ];
	assign calibrating = res_q.calibrating;
	assign calibration_done = res_q.done;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(calibrating && calibration_done))
		else $error("calibrating and calibration_done both set");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("skid stage full with empty output register");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_count_q <= CNT_W'(CAL_SAMPLES - 1))
		else $error("calibration count out of range");

	a_run_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_accept && !mode_q) |=> (cal_count_q == '0))
		else $error("run-mode item did not clear calibration count");

endmodule
